// File: rtl/core/mt19937_random_generator_assert.svh
// ---------------------------------------------------------------------------
// MT19937 generator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef MT19937_RANDOM_GENERATOR_ASSERT_SVH
`define MT19937_RANDOM_GENERATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MTRG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MTRG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/mtrg_pkg.sv
// ---------------------------------------------------------------------------
// MT19937 generator package
// Sizes, constants, sequencer states and the word-level functions.
// ---------------------------------------------------------------------------
package mtrg_pkg;

  localparam int STATE_WORDS  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int TAP_BACK     = STATE_WORDS - TWIST_OFFSET;
  localparam int WORD_W       = 32;
  localparam int ADDR_W       = $clog2(STATE_WORDS);

  localparam logic [WORD_W-1:0] MATRIX_A  = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] INIT_MULT = 32'd1812433253;
  localparam logic [WORD_W-1:0] TEMPER_B  = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C  = 32'hefc6_0000;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STATE_WORDS - 1);
  localparam logic [ADDR_W-1:0] FULL_IDX  = ADDR_W'(STATE_WORDS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_TW_PRIME,
    ST_TWIST,
    ST_TW_DRAIN,
    ST_READ,
    ST_TEMPER
  } state_t;

  // One step of the seeding recurrence: next word from the previous one.
  function automatic logic [WORD_W-1:0] init_step(input logic [WORD_W-1:0] p,
                                                  input logic [ADDR_W-1:0] k);
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] m;
    x = p ^ (p >> 30);
    m = x * INIT_MULT;
    return m + WORD_W'(k);
  endfunction

  // One word of the twist: high bit of the current word, low bits of the next.
  function automatic logic [WORD_W-1:0] twist_word(input logic [WORD_W-1:0] cur,
                                                   input logic [WORD_W-1:0] nxt,
                                                   input logic [WORD_W-1:0] tap);
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] v;
    y = {cur[WORD_W-1], nxt[WORD_W-2:0]};
    v = tap ^ (y >> 1);
    if (y[0]) begin
      v = v ^ MATRIX_A;
    end
    return v;
  endfunction

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// File: rtl/core/mtrg_ram.sv
// ---------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and two read ports, read data registered.
// ---------------------------------------------------------------------------
module mtrg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// File: rtl/core/mt19937_random_generator.sv
// ---------------------------------------------------------------------------
// MT19937 random word generator
// 32-bit Mersenne Twister with the state held in a two-read-port RAM.
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A reseed item writes
// the whole 624-word state, one word per cycle, keeping busy high while it
// does; it gives no result. A next item keeps busy high through a state
// read, then tempering, and its word appears on out_random_word with
// out_valid high for exactly one cycle, the first cycle in which busy is low
// again, so the next item may be started in that same cycle. The receiver
// cannot stall the result. Before the first word after a reseed, and again
// after every 624 words, the state is regenerated first: one prime read, then
// one RAM word per cycle, then a drain step that writes the last word.
// The state RAM is written at most once per cycle.
// A reseed must come before the first next item.
`include "mt19937_random_generator_assert.svh"

module mt19937_random_generator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_action,
  input  logic [mtrg_pkg::WORD_W-1:0] in_seed_value,
  output logic                       out_valid,
  output logic [mtrg_pkg::WORD_W-1:0] out_random_word
);

  import mtrg_pkg::*;

  // Sequencer state and counters.
  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;        // next word to hand out
  logic [ADDR_W-1:0] k_r, k_nxt;            // seed / twist issue position
  logic              cmp_vld_r, cmp_vld_nxt; // twist compute stage holds a word
  logic              out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [ADDR_W-1:0] cmp_k_r, cmp_k_nxt;    // address of the word being computed
  logic [WORD_W-1:0] prev_r, prev_nxt;      // previous seed word
  logic [WORD_W-1:0] cur_r, cur_nxt;        // old value of the word being twisted
  logic [WORD_W-1:0] out_word_r, out_word_nxt;

  // RAM port signals.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr_a;
  logic [ADDR_W-1:0] ram_raddr_b;
  logic [WORD_W-1:0] ram_rdata_a;
  logic [WORD_W-1:0] ram_rdata_b;

  logic accept;

  mtrg_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STATE_WORDS)
  ) u_state_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Next state and datapath control.
  // The twist runs as a two-stage pipeline. In the issue stage for word k the
  // RAM is asked for word k+1 (port A) and the tap word (port B), and the old
  // word k, which arrived on port A from the previous issue, is captured in
  // cur_r. In the compute stage both reads are back and the new word k is
  // written. The tap of a late word points back to a word rewritten long
  // before, and the final word's neighbor is the new word 0, so the in-place
  // update matches a strictly sequential pass without any forwarding.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    cmp_vld_nxt   = 1'b0;
    out_valid_nxt = 1'b0;
    cmp_k_nxt     = cmp_k_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    out_word_nxt  = out_word_r;

    ram_we      = 1'b0;
    ram_waddr   = cmp_k_r;
    ram_wdata   = twist_word(cur_r, ram_rdata_a, ram_rdata_b);
    ram_raddr_a = idx_r;
    ram_raddr_b = idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          k_nxt = '0;
          if (in_action) begin
            prev_nxt  = in_seed_value;
            state_nxt = ST_SEED;
          end else if (idx_r >= FULL_IDX) begin
            state_nxt = ST_TW_PRIME;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end

      ST_SEED: begin
        ram_we    = 1'b1;
        ram_waddr = k_r;
        ram_wdata = prev_r;
        prev_nxt  = init_step(prev_r, k_r + ADDR_W'(1));
        if (k_r == LAST_ADDR) begin
          idx_nxt   = FULL_IDX;
          state_nxt = ST_IDLE;
        end else begin
          k_nxt = k_r + ADDR_W'(1);
        end
      end

      ST_TW_PRIME: begin
        // Fetch old word 0 so the first issue can capture it.
        ram_raddr_a = '0;
        state_nxt   = ST_TWIST;
      end

      ST_TWIST: begin
        ram_we      = cmp_vld_r;
        ram_raddr_a = (k_r == LAST_ADDR) ? '0 : k_r + ADDR_W'(1);
        ram_raddr_b = (k_r < ADDR_W'(TAP_BACK)) ? k_r + ADDR_W'(TWIST_OFFSET)
                                                : k_r - ADDR_W'(TAP_BACK);
        cur_nxt     = ram_rdata_a;
        cmp_vld_nxt = 1'b1;
        cmp_k_nxt   = k_r;
        if (k_r == LAST_ADDR) begin
          state_nxt = ST_TW_DRAIN;
        end else begin
          k_nxt = k_r + ADDR_W'(1);
        end
      end

      ST_TW_DRAIN: begin
        // Write the last regenerated word, then serve the pending request.
        ram_we    = cmp_vld_r;
        idx_nxt   = '0;
        state_nxt = ST_READ;
      end

      ST_READ: begin
        ram_raddr_a = idx_r;
        idx_nxt     = idx_r + ADDR_W'(1);
        state_nxt   = ST_TEMPER;
      end

      ST_TEMPER: begin
        out_word_nxt  = temper(ram_rdata_a);
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= FULL_IDX;
      k_r         <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      k_r         <= k_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmp_k_r    <= cmp_k_nxt;
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

  // A word is only ever shown after the index moved past the word it came from.
  `MTRG_ASSERT_SAME(a_out_idx_moved, out_valid_r, idx_r != '0, "output with index at zero")
  // The RAM is never written while the block reports idle.
  `MTRG_ASSERT_SAME(a_no_idle_write, ram_we, state_r != ST_IDLE, "state write while idle")
  // During the twist a write never hits an entry being read in the same cycle.
  `MTRG_ASSERT_SAME(a_twist_no_collide, ram_we && state_r == ST_TWIST,
                    ram_waddr != ram_raddr_a && ram_waddr != ram_raddr_b,
                    "twist write collides with a read")
  // A next item always produces busy in the following cycle.
  `MTRG_ASSERT_NEXT(a_next_busy, accept && !in_action, busy, "next item not started")
  // A result strobe lasts exactly one cycle.
  `MTRG_ASSERT_NEXT(a_strobe_single, out_valid_r, !out_valid_r, "result strobe held")

endmodule
